>>> hdl/idsu_pkg.sv
`default_nettype none
package idsu_pkg;

	localparam int FRAC_BITS = 16;
	localparam int DATA_W = 32;
	localparam int CFG_W = 31;
	localparam int MUL_W = DATA_W + 1;
	localparam int PROD_W = 2 * MUL_W - FRAC_BITS;
	localparam int ACC_W = PROD_W + 4;
	localparam int ENERGY_W = 62 - FRAC_BITS;
	localparam int ROOT_W = 31;
	localparam int RAD_W = 2 * ROOT_W;
	localparam int FACT_W = FRAC_BITS + 1;
	localparam int CNT_W = 6;

	localparam int SQRT_STEPS = ROOT_W;
	localparam int DIV_STEPS = ROOT_W;
	localparam int STRESS_PRODUCTS = 12;
	localparam int ENERGY_TERMS = 6;
	localparam int HARD_STEPS = 3;
	localparam int FC_TERMS = 3;
	localparam int ROW_STEPS = 8;

	localparam logic [2:0] LAST_ROW = 3'd5;
	localparam logic [2:0] LAST_DIV = 3'd7;
	localparam logic [2:0] DIV_F = 3'd0;

	localparam logic [1:0] KIND_EVAL = 2'd0;
	localparam logic [1:0] KIND_COMMIT = 2'd1;
	localparam logic [1:0] KIND_CLEAR = 2'd2;

	localparam logic [2:0] REG_NORMAL_DIAG = 3'd0;
	localparam logic [2:0] REG_NORMAL_OFF = 3'd1;
	localparam logic [2:0] REG_SHEAR_DIAG = 3'd2;
	localparam logic [2:0] REG_THRESHOLD = 3'd3;
	localparam logic [2:0] REG_SATURATION = 3'd4;
	localparam logic [2:0] REG_HARDENING = 3'd5;

	typedef enum logic [3:0] {
		ST_IDLE, ST_STRESS, ST_ENERGY, ST_SQRT, ST_HARD, ST_DIV, ST_FC, ST_ROW, ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		M_NONE, M_CE, M_SE, M_HD, M_HR, M_FC, M_KN, M_FS, M_KNN
	} mul_sel_t;

	typedef enum logic [4:0] {
		P_NONE, P_LOAD, P_STRESS_ACC, P_ENERGY_ACC, P_SQ_INIT, P_SQ_STEP, P_CLASSIFY,
		P_Q, P_NUM, P_DIV_LOAD, P_DIV_STEP, P_DIV_STORE, P_FC, P_KN, P_SROW, P_TAN,
		P_OUT_LOAD
	} dp_op_t;

	typedef struct packed {
		mul_sel_t issue;
		logic [3:0] issue_idx;
		dp_op_t op;
		logic [3:0] op_idx;
		logic [2:0] row;
	} dp_cmd_t;

	typedef struct packed {
		logic inelastic;
	} dp_status_t;

endpackage
`default_nettype wire

>>> hdl/isotropic_damage_stress_update_core.sv
`default_nettype none
// Isotropic damage stress update with linear hardening for one material point, in signed
// Q16.16. One shared 33x33 multiplier, a one-bit-per-cycle square root and a one-bit-per-cycle
// divider work in turn under a sequencer, one item at a time. An inelastic point runs eight
// divisions and an elastic point only the first; the result rows then take their turns on
// the multiplier, and each row can be held while the output is stalled. A clear item resets
// the history and gives no result rows. Six result rows follow each evaluate or commit
// transaction; the next item is accepted while the last row still waits to be taken.
module isotropic_damage_stress_update_core (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic write_enable,
	input  wire logic [2:0] write_index,
	input  wire logic [31:0] write_data,
	input  wire logic in_valid,
	output logic in_stall,
	input  wire logic [1:0] kind,
	input  wire logic signed [31:0] strain_xx,
	input  wire logic signed [31:0] strain_yy,
	input  wire logic signed [31:0] strain_zz,
	input  wire logic signed [31:0] strain_shear_a,
	input  wire logic signed [31:0] strain_shear_b,
	input  wire logic signed [31:0] strain_shear_c,
	output logic out_valid,
	input  wire logic out_stall,
	output logic [2:0] row,
	output logic signed [31:0] stress,
	output logic signed [31:0] tangent_col0,
	output logic signed [31:0] tangent_col1,
	output logic signed [31:0] tangent_col2,
	output logic signed [31:0] tangent_col3,
	output logic signed [31:0] tangent_col4,
	output logic signed [31:0] tangent_col5,
	output logic [16:0] damage,
	output logic inelastic,
	output logic last
);

	idsu_pkg::dp_cmd_t cmd;
	idsu_pkg::dp_status_t status;

	idsu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.kind     (kind),
		.out_stall(out_stall),
		.status   (status),
		.cmd      (cmd),
		.in_stall (in_stall),
		.out_valid(out_valid)
	);

	idsu_datapath u_datapath (
		.clk           (clk),
		.arst_n        (arst_n),
		.write_enable  (write_enable),
		.write_index   (write_index),
		.write_data    (write_data),
		.kind          (kind),
		.strain_xx     (strain_xx),
		.strain_yy     (strain_yy),
		.strain_zz     (strain_zz),
		.strain_shear_a(strain_shear_a),
		.strain_shear_b(strain_shear_b),
		.strain_shear_c(strain_shear_c),
		.cmd           (cmd),
		.status        (status),
		.row           (row),
		.stress        (stress),
		.tangent_col0  (tangent_col0),
		.tangent_col1  (tangent_col1),
		.tangent_col2  (tangent_col2),
		.tangent_col3  (tangent_col3),
		.tangent_col4  (tangent_col4),
		.tangent_col5  (tangent_col5),
		.damage        (damage),
		.inelastic     (inelastic),
		.last          (last)
	);

endmodule
`default_nettype wire

>>> hdl/idsu_mul.sv
`default_nettype none
module idsu_mul (
	input  wire logic clk,
	input  wire logic signed [idsu_pkg::MUL_W-1:0] a,
	input  wire logic signed [idsu_pkg::MUL_W-1:0] b,
	output logic signed [idsu_pkg::PROD_W-1:0] p_s1
);

	logic signed [2*idsu_pkg::MUL_W-1:0] prod;

	assign prod = a * b;

	// Dropping the fraction bits of a two's complement product floors it.
	always_ff @(posedge clk) begin
		p_s1 <= prod[2*idsu_pkg::MUL_W-1:idsu_pkg::FRAC_BITS];
	end

endmodule
`default_nettype wire

>>> hdl/idsu_datapath.sv
`default_nettype none
module idsu_datapath (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic write_enable,
	input  wire logic [2:0] write_index,
	input  wire logic [31:0] write_data,
	input  wire logic [1:0] kind,
	input  wire logic signed [31:0] strain_xx,
	input  wire logic signed [31:0] strain_yy,
	input  wire logic signed [31:0] strain_zz,
	input  wire logic signed [31:0] strain_shear_a,
	input  wire logic signed [31:0] strain_shear_b,
	input  wire logic signed [31:0] strain_shear_c,
	input  wire idsu_pkg::dp_cmd_t cmd,
	output idsu_pkg::dp_status_t status,
	output logic [2:0] row,
	output logic signed [31:0] stress,
	output logic signed [31:0] tangent_col0,
	output logic signed [31:0] tangent_col1,
	output logic signed [31:0] tangent_col2,
	output logic signed [31:0] tangent_col3,
	output logic signed [31:0] tangent_col4,
	output logic signed [31:0] tangent_col5,
	output logic [16:0] damage,
	output logic inelastic,
	output logic last
);

	localparam int AW = idsu_pkg::ACC_W;
	localparam int PW = idsu_pkg::PROD_W;
	localparam int MW = idsu_pkg::MUL_W;
	localparam int RW = idsu_pkg::ROOT_W;
	localparam int CW = idsu_pkg::CFG_W;
	localparam int FW = idsu_pkg::FACT_W;
	localparam int DD_W = idsu_pkg::DATA_W + idsu_pkg::FRAC_BITS;
	localparam int HI_W = DD_W - RW;
	localparam logic [FW-1:0] ONE = FW'(1) << idsu_pkg::FRAC_BITS;

	function automatic logic signed [31:0] sat32(input logic signed [AW-1:0] x);
		logic signed [31:0] res;
		if (x[AW-1:31] == '0 || x[AW-1:31] == '1) begin
			res = x[31:0];
		end else if (x[AW-1]) begin
			res = 32'sh8000_0000;
		end else begin
			res = 32'sh7fff_ffff;
		end
		return res;
	endfunction

	// Order of the stress products: three per normal row, one per shear row.
	function automatic logic [2:0] ce_row(input logic [3:0] p);
		logic [2:0] r;
		unique case (p) inside
			4'd0, 4'd1, 4'd2: r = 3'd0;
			4'd3, 4'd4, 4'd5: r = 3'd1;
			4'd6, 4'd7, 4'd8: r = 3'd2;
			4'd9: r = 3'd3;
			4'd10: r = 3'd4;
			4'd11: r = 3'd5;
			default: r = 3'd0;
		endcase
		return r;
	endfunction

	function automatic logic [2:0] ce_col(input logic [3:0] p);
		logic [2:0] c;
		unique case (p) inside
			4'd0, 4'd3, 4'd6: c = 3'd0;
			4'd1, 4'd4, 4'd7: c = 3'd1;
			4'd2, 4'd5, 4'd8: c = 3'd2;
			4'd9: c = 3'd3;
			4'd10: c = 3'd4;
			4'd11: c = 3'd5;
			default: c = 3'd0;
		endcase
		return c;
	endfunction

	logic [CW-1:0] nd_q, no_q, sd_q, r0_q, qinf_q;
	logic signed [31:0] hm_q;
	logic [RW-1:0] hist_q;

	logic signed [31:0] e_q [0:5];
	logic signed [31:0] s_q [0:5];
	logic signed [31:0] n_q [0:5];
	logic signed [31:0] t_q [0:5];
	logic commit_q;
	logic signed [AW-1:0] acc_q;
	logic [2*RW-1:0] rad_q;
	logic [RW+1:0] rem_q;
	logic [RW-1:0] root_q;
	logic inel_q;
	logic [RW-1:0] ru_q;
	logic signed [PW-1:0] q_q;
	logic signed [31:0] num_q;
	logic [RW-1:0] drem_q;
	logic [RW-1:0] dlow_q;
	logic [RW-1:0] quo_q;
	logic dneg_q, dovf_q;
	logic [FW-1:0] f_q;
	logic signed [31:0] k_q, kn_q, st_q;
	logic signed [MW-1:0] fc_q [0:2];

	logic [2:0] row_q;
	logic signed [31:0] stress_q;
	logic signed [31:0] tout_q [0:5];
	logic [16:0] damage_q;
	logic inelastic_q, last_q;

	logic signed [MW-1:0] ma, mb;
	logic signed [PW-1:0] p_s1;
	logic signed [AW-1:0] acc_sum;
	logic [CW-1:0] ce_coef;
	logic [2:0] ci, cj;
	logic [idsu_pkg::ENERGY_W-1:0] energy;
	logic [RW+3:0] rem_sh, trial;
	logic [RW-1:0] h_max;
	logic signed [PW-1:0] q_raw, q_new, r0_ext, qinf_ext;
	logic signed [MW-1:0] div_x, div_mag;
	logic [DD_W-1:0] div_dd;
	logic [RW:0] div_t;
	logic signed [31:0] div_res;
	logic [FW-1:0] f_new;
	logic signed [MW-1:0] fc_sel;
	logic [2:0] tj;

	idsu_mul u_mul (
		.clk (clk),
		.a   (ma),
		.b   (mb),
		.p_s1(p_s1)
	);

	always_comb begin
		ci = ce_row(cmd.issue_idx);
		cj = ce_col(cmd.issue_idx);
		if (ci < 3'd3) begin
			ce_coef = (ci == cj) ? nd_q : no_q;
		end else begin
			ce_coef = sd_q;
		end
	end

	always_comb begin
		ma = '0;
		mb = '0;
		case (cmd.issue)
			idsu_pkg::M_CE: begin
				ma = $signed({2'b00, ce_coef});
				mb = MW'(e_q[cj]);
			end
			idsu_pkg::M_SE: begin
				ma = MW'(s_q[cmd.issue_idx[2:0]]);
				mb = MW'(e_q[cmd.issue_idx[2:0]]);
			end
			idsu_pkg::M_HD: begin
				ma = MW'(hm_q);
				mb = $signed({2'b00, ru_q}) - $signed({2'b00, r0_q});
			end
			idsu_pkg::M_HR: begin
				ma = MW'(hm_q);
				mb = $signed({2'b00, ru_q});
			end
			idsu_pkg::M_FC: begin
				ma = $signed({{(MW - FW){1'b0}}, f_q});
				if (cmd.issue_idx[1:0] == 2'd0) begin
					mb = $signed({2'b00, nd_q});
				end else if (cmd.issue_idx[1:0] == 2'd1) begin
					mb = $signed({2'b00, no_q});
				end else begin
					mb = $signed({2'b00, sd_q});
				end
			end
			idsu_pkg::M_KN: begin
				ma = MW'(k_q);
				mb = MW'(n_q[cmd.row]);
			end
			idsu_pkg::M_FS: begin
				ma = $signed({{(MW - FW){1'b0}}, f_q});
				mb = MW'(s_q[cmd.row]);
			end
			idsu_pkg::M_KNN: begin
				ma = MW'(kn_q);
				mb = MW'(n_q[cmd.issue_idx[2:0]]);
			end
			default: begin
				ma = '0;
				mb = '0;
			end
		endcase
	end

	assign acc_sum = acc_q + AW'(p_s1);

	always_comb begin
		if (acc_q[AW-1]) begin
			energy = '0;
		end else if (acc_q[AW-2:idsu_pkg::ENERGY_W] != '0) begin
			energy = '1;
		end else begin
			energy = acc_q[idsu_pkg::ENERGY_W-1:0];
		end
	end

	assign rem_sh = {rem_q, rad_q[2*RW-1 -: 2]};
	assign trial = {2'b00, root_q, 2'b01};
	assign h_max = ({1'b0, hist_q} > {1'b0, r0_q}) ? hist_q : r0_q;

	assign r0_ext = $signed({{(PW - CW){1'b0}}, r0_q});
	assign qinf_ext = $signed({{(PW - CW){1'b0}}, qinf_q});

	always_comb begin
		if (ru_q < r0_q) begin
			q_raw = $signed({{(PW - RW){1'b0}}, ru_q});
		end else begin
			q_raw = r0_ext + p_s1;
		end
		q_new = q_raw;
		if (hm_q > 32'sd0) begin
			if (q_raw > qinf_ext) begin
				q_new = qinf_ext;
			end
		end else if (q_raw < qinf_ext) begin
			q_new = qinf_ext;
		end
	end

	// Dividend selection: the hardening variable, the tangent scale, then the stresses.
	always_comb begin
		if (cmd.op_idx[2:0] == idsu_pkg::DIV_F) begin
			div_x = $signed({2'b00, q_q[RW-1:0]});
		end else if (cmd.op_idx[2:0] == 3'd1) begin
			div_x = MW'(num_q);
		end else begin
			div_x = MW'(s_q[cmd.op_idx[2:0] - 3'd2]);
		end
		div_mag = div_x[MW-1] ? -div_x : div_x;
		div_dd = {div_mag[31:0], {idsu_pkg::FRAC_BITS{1'b0}}};
	end

	assign div_t = {drem_q, dlow_q[RW-1]};

	always_comb begin
		if (dovf_q) begin
			div_res = dneg_q ? 32'sh8000_0000 : 32'sh7fff_ffff;
		end else if (dneg_q) begin
			div_res = -$signed({1'b0, quo_q});
		end else begin
			div_res = $signed({1'b0, quo_q});
		end
		if (ru_q == '0) begin
			f_new = ONE;
		end else if (q_q <= 0) begin
			f_new = '0;
		end else if (q_q >= $signed({{(PW - RW){1'b0}}, ru_q})) begin
			f_new = ONE;
		end else begin
			f_new = quo_q[FW-1:0];
		end
	end

	assign tj = cmd.op_idx[2:0];

	always_comb begin
		if (cmd.row < 3'd3 && tj < 3'd3) begin
			fc_sel = (cmd.row == tj) ? fc_q[0] : fc_q[1];
		end else if (cmd.row == tj) begin
			fc_sel = fc_q[2];
		end else begin
			fc_sel = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			nd_q <= '0;
			no_q <= '0;
			sd_q <= '0;
			r0_q <= '0;
			qinf_q <= '0;
			hm_q <= '0;
			hist_q <= '0;
		end else begin
			if (write_enable) begin
				unique case (write_index)
					idsu_pkg::REG_NORMAL_DIAG: nd_q <= write_data[CW-1:0];
					idsu_pkg::REG_NORMAL_OFF: no_q <= write_data[CW-1:0];
					idsu_pkg::REG_SHEAR_DIAG: sd_q <= write_data[CW-1:0];
					idsu_pkg::REG_THRESHOLD: r0_q <= write_data[CW-1:0];
					idsu_pkg::REG_SATURATION: qinf_q <= write_data[CW-1:0];
					idsu_pkg::REG_HARDENING: hm_q <= write_data;
					default: ;
				endcase
			end
			if (cmd.op == idsu_pkg::P_LOAD && kind == idsu_pkg::KIND_CLEAR) begin
				hist_q <= '0;
			end else if (cmd.op == idsu_pkg::P_OUT_LOAD && cmd.row == idsu_pkg::LAST_ROW
					&& commit_q) begin
				hist_q <= ru_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			idsu_pkg::P_LOAD: begin
				e_q[0] <= strain_xx;
				e_q[1] <= strain_yy;
				e_q[2] <= strain_zz;
				e_q[3] <= strain_shear_a;
				e_q[4] <= strain_shear_b;
				e_q[5] <= strain_shear_c;
				commit_q <= (kind == idsu_pkg::KIND_COMMIT);
				acc_q <= '0;
			end
			idsu_pkg::P_STRESS_ACC: begin
				if (ce_col(cmd.op_idx) == 3'd2 || ce_row(cmd.op_idx) > 3'd2) begin
					s_q[ce_row(cmd.op_idx)] <= sat32(acc_sum);
					acc_q <= '0;
				end else begin
					acc_q <= acc_sum;
				end
			end
			idsu_pkg::P_ENERGY_ACC: acc_q <= acc_sum;
			idsu_pkg::P_SQ_INIT: begin
				rad_q <= {energy, {idsu_pkg::FRAC_BITS{1'b0}}};
				rem_q <= '0;
				root_q <= '0;
			end
			idsu_pkg::P_SQ_STEP: begin
				rad_q <= {rad_q[2*RW-3:0], 2'b00};
				if (rem_sh >= trial) begin
					rem_q <= rem_sh[RW+1:0] - trial[RW+1:0];
					root_q <= {root_q[RW-2:0], 1'b1};
				end else begin
					rem_q <= rem_sh[RW+1:0];
					root_q <= {root_q[RW-2:0], 1'b0};
				end
			end
			idsu_pkg::P_CLASSIFY: begin
				inel_q <= root_q > h_max;
				ru_q <= (root_q > h_max) ? root_q : h_max;
				k_q <= '0;
				for (int i = 0; i < 6; i++) begin
					n_q[i] <= '0;
				end
			end
			idsu_pkg::P_Q: q_q <= q_new;
			idsu_pkg::P_NUM: num_q <= sat32(AW'(q_q) - AW'(p_s1));
			idsu_pkg::P_DIV_LOAD: begin
				dneg_q <= div_x[MW-1];
				dovf_q <= {{(RW - HI_W){1'b0}}, div_dd[DD_W-1:RW]} >= ru_q;
				drem_q <= {{(RW - HI_W){1'b0}}, div_dd[DD_W-1:RW]};
				dlow_q <= div_dd[RW-1:0];
				quo_q <= '0;
			end
			idsu_pkg::P_DIV_STEP: begin
				dlow_q <= {dlow_q[RW-2:0], 1'b0};
				if (div_t >= {1'b0, ru_q}) begin
					drem_q <= div_t[RW-1:0] - ru_q;
					quo_q <= {quo_q[RW-2:0], 1'b1};
				end else begin
					drem_q <= div_t[RW-1:0];
					quo_q <= {quo_q[RW-2:0], 1'b0};
				end
			end
			idsu_pkg::P_DIV_STORE: begin
				if (cmd.op_idx[2:0] == idsu_pkg::DIV_F) begin
					f_q <= f_new;
				end else if (cmd.op_idx[2:0] == 3'd1) begin
					k_q <= div_res;
				end else begin
					n_q[cmd.op_idx[2:0] - 3'd2] <= div_res;
				end
			end
			idsu_pkg::P_FC: fc_q[cmd.op_idx[1:0]] <= p_s1[MW-1:0];
			idsu_pkg::P_KN: kn_q <= sat32(AW'(p_s1));
			idsu_pkg::P_SROW: st_q <= sat32(AW'(p_s1));
			idsu_pkg::P_TAN: t_q[tj] <= sat32(AW'(fc_sel) - AW'(p_s1));
			idsu_pkg::P_OUT_LOAD: begin
				row_q <= cmd.row;
				stress_q <= st_q;
				for (int i = 0; i < 6; i++) begin
					tout_q[i] <= t_q[i];
				end
				damage_q <= ONE - f_q;
				inelastic_q <= inel_q;
				last_q <= (cmd.row == idsu_pkg::LAST_ROW);
			end
			default: ;
		endcase
	end

	assign status.inelastic = inel_q;
	assign row = row_q;
	assign stress = stress_q;
	assign tangent_col0 = tout_q[0];
	assign tangent_col1 = tout_q[1];
	assign tangent_col2 = tout_q[2];
	assign tangent_col3 = tout_q[3];
	assign tangent_col4 = tout_q[4];
	assign tangent_col5 = tout_q[5];
	assign damage = damage_q;
	assign inelastic = inelastic_q;
	assign last = last_q;

endmodule
`default_nettype wire

>>> hdl/idsu_ctrl.sv
`default_nettype none
module idsu_ctrl (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic [1:0] kind,
	input  wire logic out_stall,
	input  wire idsu_pkg::dp_status_t status,
	output idsu_pkg::dp_cmd_t cmd,
	output logic in_stall,
	output logic out_valid
);

	localparam int CW = idsu_pkg::CNT_W;

	idsu_pkg::state_t state_q, state_d;
	logic [CW-1:0] cnt_q, cnt_d, cnt_m1, cnt_m2, cnt_m3;
	logic [2:0] div_q, div_d;
	logic [2:0] row_q, row_d;
	logic out_valid_q;
	logic emit_go;

	assign cnt_m1 = cnt_q - CW'(1);
	assign cnt_m2 = cnt_q - CW'(2);
	assign cnt_m3 = cnt_q - CW'(3);
	assign emit_go = !out_valid_q || !out_stall;

	always_comb begin
		state_d = state_q;
		cnt_d = cnt_q + CW'(1);
		div_d = div_q;
		row_d = row_q;
		unique case (state_q)
			idsu_pkg::ST_IDLE: begin
				cnt_d = '0;
				if (in_valid && kind != idsu_pkg::KIND_CLEAR) begin
					state_d = idsu_pkg::ST_STRESS;
				end
			end
			idsu_pkg::ST_STRESS: begin
				if (cnt_q == CW'(idsu_pkg::STRESS_PRODUCTS)) begin
					state_d = idsu_pkg::ST_ENERGY;
					cnt_d = '0;
				end
			end
			idsu_pkg::ST_ENERGY: begin
				if (cnt_q == CW'(idsu_pkg::ENERGY_TERMS)) begin
					state_d = idsu_pkg::ST_SQRT;
					cnt_d = '0;
				end
			end
			idsu_pkg::ST_SQRT: begin
				if (cnt_q == CW'(idsu_pkg::SQRT_STEPS)) begin
					state_d = idsu_pkg::ST_HARD;
					cnt_d = '0;
				end
			end
			idsu_pkg::ST_HARD: begin
				if (cnt_q == CW'(idsu_pkg::HARD_STEPS)) begin
					state_d = idsu_pkg::ST_DIV;
					cnt_d = '0;
					div_d = idsu_pkg::DIV_F;
				end
			end
			idsu_pkg::ST_DIV: begin
				if (cnt_q == CW'(idsu_pkg::DIV_STEPS + 1)) begin
					cnt_d = '0;
					// An elastic point needs only the damage factor.
					if ((div_q == idsu_pkg::DIV_F && !status.inelastic)
							|| div_q == idsu_pkg::LAST_DIV) begin
						state_d = idsu_pkg::ST_FC;
					end else begin
						div_d = div_q + 3'd1;
					end
				end
			end
			idsu_pkg::ST_FC: begin
				if (cnt_q == CW'(idsu_pkg::FC_TERMS)) begin
					state_d = idsu_pkg::ST_ROW;
					cnt_d = '0;
					row_d = '0;
				end
			end
			idsu_pkg::ST_ROW: begin
				if (cnt_q == CW'(idsu_pkg::ROW_STEPS)) begin
					state_d = idsu_pkg::ST_EMIT;
					cnt_d = '0;
				end
			end
			idsu_pkg::ST_EMIT: begin
				cnt_d = '0;
				if (emit_go) begin
					if (row_q == idsu_pkg::LAST_ROW) begin
						state_d = idsu_pkg::ST_IDLE;
					end else begin
						state_d = idsu_pkg::ST_ROW;
						row_d = row_q + 3'd1;
					end
				end
			end
			default: begin
				state_d = idsu_pkg::ST_IDLE;
				cnt_d = '0;
			end
		endcase
	end

	always_comb begin
		cmd.issue = idsu_pkg::M_NONE;
		cmd.issue_idx = '0;
		cmd.op = idsu_pkg::P_NONE;
		cmd.op_idx = '0;
		cmd.row = row_q;
		unique case (state_q)
			idsu_pkg::ST_IDLE: begin
				if (in_valid) begin
					cmd.op = idsu_pkg::P_LOAD;
				end
			end
			idsu_pkg::ST_STRESS: begin
				if (cnt_q < CW'(idsu_pkg::STRESS_PRODUCTS)) begin
					cmd.issue = idsu_pkg::M_CE;
					cmd.issue_idx = cnt_q[3:0];
				end
				if (cnt_q != '0) begin
					cmd.op = idsu_pkg::P_STRESS_ACC;
					cmd.op_idx = cnt_m1[3:0];
				end
			end
			idsu_pkg::ST_ENERGY: begin
				if (cnt_q < CW'(idsu_pkg::ENERGY_TERMS)) begin
					cmd.issue = idsu_pkg::M_SE;
					cmd.issue_idx = cnt_q[3:0];
				end
				if (cnt_q != '0) begin
					cmd.op = idsu_pkg::P_ENERGY_ACC;
				end
			end
			idsu_pkg::ST_SQRT: begin
				cmd.op = (cnt_q == '0) ? idsu_pkg::P_SQ_INIT : idsu_pkg::P_SQ_STEP;
			end
			idsu_pkg::ST_HARD: begin
				if (cnt_q == CW'(0)) begin
					cmd.op = idsu_pkg::P_CLASSIFY;
				end else if (cnt_q == CW'(1)) begin
					cmd.issue = idsu_pkg::M_HD;
				end else if (cnt_q == CW'(2)) begin
					cmd.op = idsu_pkg::P_Q;
					cmd.issue = idsu_pkg::M_HR;
				end else begin
					cmd.op = idsu_pkg::P_NUM;
				end
			end
			idsu_pkg::ST_DIV: begin
				cmd.op_idx = {1'b0, div_q};
				if (cnt_q == '0) begin
					cmd.op = idsu_pkg::P_DIV_LOAD;
				end else if (cnt_q == CW'(idsu_pkg::DIV_STEPS + 1)) begin
					cmd.op = idsu_pkg::P_DIV_STORE;
				end else begin
					cmd.op = idsu_pkg::P_DIV_STEP;
				end
			end
			idsu_pkg::ST_FC: begin
				if (cnt_q < CW'(idsu_pkg::FC_TERMS)) begin
					cmd.issue = idsu_pkg::M_FC;
					cmd.issue_idx = cnt_q[3:0];
				end
				if (cnt_q != '0) begin
					cmd.op = idsu_pkg::P_FC;
					cmd.op_idx = cnt_m1[3:0];
				end
			end
			idsu_pkg::ST_ROW: begin
				if (cnt_q == CW'(0)) begin
					cmd.issue = idsu_pkg::M_KN;
				end else if (cnt_q == CW'(1)) begin
					cmd.issue = idsu_pkg::M_FS;
					cmd.op = idsu_pkg::P_KN;
				end else begin
					if (cnt_q < CW'(idsu_pkg::ROW_STEPS)) begin
						cmd.issue = idsu_pkg::M_KNN;
						cmd.issue_idx = cnt_m2[3:0];
					end
					if (cnt_q == CW'(2)) begin
						cmd.op = idsu_pkg::P_SROW;
					end else begin
						cmd.op = idsu_pkg::P_TAN;
						cmd.op_idx = cnt_m3[3:0];
					end
				end
			end
			idsu_pkg::ST_EMIT: begin
				if (emit_go) begin
					cmd.op = idsu_pkg::P_OUT_LOAD;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= idsu_pkg::ST_IDLE;
			cnt_q <= '0;
			div_q <= '0;
			row_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			cnt_q <= cnt_d;
			div_q <= div_d;
			row_q <= row_d;
			if (state_q == idsu_pkg::ST_EMIT && emit_go) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_stall = (state_q != idsu_pkg::ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_last_row_ends: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idsu_pkg::ST_EMIT && emit_go && row_q == idsu_pkg::LAST_ROW)
		|=> state_q == idsu_pkg::ST_IDLE)
		else $error("item did not finish after its last row");
	a_valid_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == idsu_pkg::ST_EMIT))
		else $error("result shown outside the emit step");
	a_k_only_inelastic: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == idsu_pkg::ST_DIV && div_q != idsu_pkg::DIV_F) |-> status.inelastic)
		else $error("tangent correction divided for an elastic point");
`endif

endmodule
`default_nettype wire
